@@ rtl/latin_square_checker_macros.svh @@
// Assertion macros used by the checker top level
`ifndef LATIN_SQUARE_CHECKER_MACROS_SVH
`define LATIN_SQUARE_CHECKER_MACROS_SVH

// clocked check, masked while reset is high
`define LSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define LSC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/lsc_pkg.sv @@
// Package: widths, types and helpers of the Latin square checker
`timescale 1ns / 1ps
package lsc_pkg;

  localparam int MAX_ORDER = 64;
  localparam int IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int ORDER_W   = 7;
  localparam int SYM_W     = 8;
  localparam int WID_A     = (ORDER_W > IDX_W) ? ORDER_W : IDX_W;
  localparam int CMP_W     = ((WID_A > SYM_W) ? WID_A : SYM_W) + 1;

  typedef logic [MAX_ORDER-1:0] map_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [ORDER_W-1:0]   order_t;
  typedef logic [SYM_W-1:0]     sym_t;
  typedef logic [CMP_W-1:0]     cmp_t;

  typedef struct packed {
    map_t sym_bit;
    idx_t col;
    logic first_row;
    logic fail;
    logic last;
  } cell_op_t;

  typedef struct packed {
    logic s1_valid;
    logic s1_last;
  } check_status_t;

  function automatic cmp_t side_length(input order_t order);
    cmp_t n;
    n = cmp_t'(order);
    if (n == '0) begin
      n = cmp_t'(1);
    end else if (n > cmp_t'(MAX_ORDER)) begin
      n = cmp_t'(MAX_ORDER);
    end
    return n;
  endfunction

endpackage

@@ rtl/lsc_cell_if.sv @@
// Interfaces: cell input channel and verdict output channel
`timescale 1ns / 1ps
interface lsc_cell_if;
  logic              valid;
  logic              ready;
  lsc_pkg::sym_t     cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

interface lsc_verdict_if;
  logic valid;
  logic ready;
  logic is_latin;

  modport source (output valid, output is_latin, input ready);
  modport sink (input valid, input is_latin, output ready);
endinterface

@@ rtl/lsc_col_ram.sv @@
// Column bitmap memory: one write port, one registered read port
`timescale 1ns / 1ps
module lsc_col_ram (
  input  logic          clk,
  input  logic          re,
  input  lsc_pkg::idx_t raddr,
  output lsc_pkg::map_t rdata,
  input  logic          we,
  input  lsc_pkg::idx_t waddr,
  input  lsc_pkg::map_t wdata
);
  import lsc_pkg::*;

  map_t mem [MAX_ORDER];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

@@ rtl/lsc_front.sv @@
// Front stage: order register, cell indices, row bitmap and column read issue
`timescale 1ns / 1ps
module lsc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                order_we,
  input  lsc_pkg::order_t     order_wdata,
  lsc_cell_if.sink            cells,
  input  logic                accept_ok,
  output logic                op_valid,
  output lsc_pkg::cell_op_t   op
);
  import lsc_pkg::*;

  order_t order;
  idx_t   col_index;
  idx_t   row_index;
  map_t   row_seen;

  cmp_t   n;
  idx_t   col_c;
  logic   in_range;
  map_t   sym_bit;
  logic   col_last;
  logic   row_last;
  idx_t   col_index_next;
  idx_t   row_index_next;
  map_t   row_seen_next;

  assign cells.ready = accept_ok;
  assign op_valid    = cells.valid && accept_ok;

  always_comb begin
    n        = side_length(order);
    col_c    = (cmp_t'(col_index) >= n) ? idx_t'(n - cmp_t'(1)) : col_index;
    in_range = cmp_t'(cells.cell_value) < n;
    sym_bit  = in_range ? (map_t'(1) << cells.cell_value) : '0;
    col_last = (cmp_t'(col_c) + cmp_t'(1)) >= n;
    row_last = (cmp_t'(row_index) + cmp_t'(1)) >= n;

    op.sym_bit   = sym_bit;
    op.col       = col_c;
    op.first_row = (row_index == '0);
    op.fail      = !in_range || ((row_seen & sym_bit) != '0);
    op.last      = col_last && row_last;

    col_index_next = col_last ? '0 : idx_t'(col_c + idx_t'(1));
    row_seen_next  = col_last ? '0 : (row_seen | sym_bit);
    if (!col_last) begin
      row_index_next = row_index;
    end else if (row_last) begin
      row_index_next = '0;
    end else begin
      row_index_next = idx_t'(row_index + idx_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= order_t'(1);
    end else if (order_we) begin
      order <= order_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || order_we) begin
      col_index <= '0;
      row_index <= '0;
      row_seen  <= '0;
    end else if (op_valid) begin
      col_index <= col_index_next;
      row_index <= row_index_next;
      row_seen  <= row_seen_next;
    end
  end

endmodule

@@ rtl/lsc_check.sv @@
// Check stage: column test, bitmap write-back, fail flag and verdict register
`timescale 1ns / 1ps
module lsc_check (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    order_we,
  input  logic                    op_valid,
  input  lsc_pkg::cell_op_t       op,
  output logic                    accept_ok,
  input  lsc_pkg::map_t           rdata,
  output logic                    ram_we,
  output lsc_pkg::idx_t           ram_waddr,
  output lsc_pkg::map_t           ram_wdata,
  output lsc_pkg::check_status_t  status,
  lsc_verdict_if.source           verdict
);
  import lsc_pkg::*;

  logic     s1_valid;
  cell_op_t s1;
  logic     failed;
  logic     out_valid;
  logic     is_latin;

  logic     s1_adv;
  logic     col_dup;
  logic     cell_fail;

  always_comb begin
    s1_adv    = s1_valid && (!s1.last || !out_valid || verdict.ready);
    accept_ok = !s1_valid || s1_adv;
    col_dup   = !s1.first_row && ((rdata & s1.sym_bit) != '0);
    cell_fail = s1.fail || col_dup;
    ram_we    = s1_adv && (s1.sym_bit != '0);
    ram_waddr = s1.col;
    ram_wdata = s1.first_row ? s1.sym_bit : (rdata | s1.sym_bit);
  end

  assign status.s1_valid  = s1_valid;
  assign status.s1_last   = s1.last;
  assign verdict.valid    = out_valid;
  assign verdict.is_latin = is_latin;

  always_ff @(posedge clk) begin
    if (op_valid) begin
      s1 <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_ok) begin
      s1_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || order_we) begin
      failed <= 1'b0;
    end else if (s1_adv) begin
      failed <= s1.last ? 1'b0 : (failed || cell_fail);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1.last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.last) begin
      is_latin <= !(failed || cell_fail);
    end
  end

endmodule

@@ rtl/latin_square_checker.sv @@
// Top level of the Latin square checker
//
//   channel   dir  handshake        payload
//   cells     in   valid / ready    cell_value [7:0]
//   verdict   out  valid / ready    is_latin
//   order     in   order_we         order_wdata [6:0]
//
// One cell per cycle but for verdict stalls, set by one read-modify-write of its column bitmap.
// The last cell of a square passes the check stage register, then sets the verdict register.
// Each cell reads its column bitmap on acceptance; an in-range cell writes it back from the check stage.
// Reset is synchronous; the column memory needs no clearing pass.
// A stalled verdict holds only the last cell of the next square in the check stage.
`timescale 1ns / 1ps
`include "latin_square_checker_macros.svh"
module latin_square_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              order_we,
  input  lsc_pkg::order_t   order_wdata,
  lsc_cell_if.sink          cells,
  lsc_verdict_if.source     verdict
);
  import lsc_pkg::*;

  logic          op_valid;
  cell_op_t      op;
  logic          accept_ok;
  map_t          rdata;
  logic          ram_we;
  idx_t          ram_waddr;
  map_t          ram_wdata;
  check_status_t ck_st;
  logic          last_held;

  assign last_held = ck_st.s1_valid && ck_st.s1_last;

  lsc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .order_we    (order_we),
    .order_wdata (order_wdata),
    .cells       (cells),
    .accept_ok   (accept_ok),
    .op_valid    (op_valid),
    .op          (op)
  );

  lsc_col_ram u_col_ram (
    .clk   (clk),
    .re    (op_valid),
    .raddr (op.col),
    .rdata (rdata),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata)
  );

  lsc_check u_check (
    .clk       (clk),
    .rst       (rst),
    .order_we  (order_we),
    .op_valid  (op_valid),
    .op        (op),
    .accept_ok (accept_ok),
    .rdata     (rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .status    (ck_st),
    .verdict   (verdict)
  );

  `LSC_ASSERT(a_stall_only_on_last, !cells.ready |-> last_held, "input stalled without last cell")
  `LSC_ASSERT(a_verdict_after_last, $rose(verdict.valid) |-> $past(last_held), "stray verdict")
  `LSC_ASSERT_RST(a_reset_idle, rst |=> (!verdict.valid && !ck_st.s1_valid), "busy after reset")

endmodule
